>>> sv/rbut_pkg.sv
// ----------------------------------------------------------------------------
// rbut_pkg
// Shared types and constants for the reference-counted binding unit table.
// ----------------------------------------------------------------------------
package rbut_pkg;

  localparam logic [1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [1:0] ACT_GET     = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_QUERY   = 2'd3;

  localparam int unsigned LINK_W = 16;
  localparam logic [LINK_W-1:0] LINK_MAX = 16'hFFFF;
  localparam logic signed [8:0] RESULT_NONE = -9'sd1;

  typedef struct packed {
    logic        [31:0]       prog_handle;
    logic signed [31:0]       bind_index;
    logic        [LINK_W-1:0] links;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic              zero;
    logic [LINK_W-1:0] links_inc;
    logic [LINK_W-1:0] links_dec;
  } match_t;

endpackage

>>> sv/rbut_mem.sv
// ----------------------------------------------------------------------------
// rbut_mem
// Entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module rbut_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rbut_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output rbut_pkg::entry_t rd_data
);
  import rbut_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/rbut_match.sv
// ----------------------------------------------------------------------------
// rbut_match
// Evaluates one entry read from the store: key compare, free check and the
// saturating link count update.
// ----------------------------------------------------------------------------
module rbut_match (
  input  rbut_pkg::entry_t    entry,
  input  logic [31:0]         key_prog,
  input  logic signed [31:0]  key_idx,
  output rbut_pkg::match_t    result
);
  import rbut_pkg::*;

  always_comb begin
    result.hit       = (entry.prog_handle == key_prog) && (entry.bind_index == key_idx);
    result.zero      = (entry.links == '0);
    result.links_inc = (entry.links == LINK_MAX) ? LINK_MAX : entry.links + LINK_W'(1);
    result.links_dec = (entry.links == '0) ? '0 : entry.links - LINK_W'(1);
  end

endmodule

>>> sv/refcounted_binding_unit_table.sv
// ----------------------------------------------------------------------------
// refcounted_binding_unit_table
// Table of binding units keyed by program handle and binding index, each with
// a saturating link count. Acquire, get, release and query, one at a time.
//
//   Channel  Handshake          Payload
//   in       in_valid/in_stall  action, program_handle, binding_index,
//                               unit_number
//   out      out_valid/out_stall unit_result, link_count_out, program_out,
//                               index_out, query_valid, table_full
//
// Acquire and get walk the used entries through the single read port of the
// entry store, one entry per cycle, and stop early when a key matches.
// Release and query read the named unit, then evaluate and write back.
// Reset clears the fill count and the handshake state; the store needs no
// clearing pass. A stalled result holds the block before its write back.
// ----------------------------------------------------------------------------
module refcounted_binding_unit_table #(
  parameter int unsigned UNITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [31:0]        program_handle,
  input  logic signed [31:0] binding_index,
  input  logic [7:0]         unit_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  unit_result,
  output logic [15:0]        link_count_out,
  output logic [31:0]        program_out,
  output logic signed [31:0] index_out,
  output logic               query_valid,
  output logic               table_full
);
  import rbut_pkg::*;

  localparam int unsigned IW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int unsigned CW = $clog2(UNITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_UNIT} state_t;

  state_t              state, state_next;
  logic [CW-1:0]       used_entries, used_next;
  logic [1:0]          act;
  logic [31:0]         key_prog;
  logic signed [31:0]  key_idx;
  logic [7:0]          unit_q;
  logic [IW-1:0]       chk_idx, chk_next;
  logic                zero_found, zero_found_next;
  logic [IW-1:0]       zero_idx, zero_idx_next;

  logic                rd_en, wr_en;
  logic [IW-1:0]       rd_addr, wr_addr;
  entry_t              rd_data, wr_data;
  match_t              m;

  logic                in_accept, can_emit, last, in_range, emit;
  logic signed [8:0]   res_unit;
  logic [15:0]         res_links;
  logic [31:0]         res_prog;
  logic signed [31:0]  res_idx;
  logic                res_valid, res_full;

  rbut_mem #(.DEPTH(UNITS), .AW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbut_match u_match (
    .entry    (rd_data),
    .key_prog (key_prog),
    .key_idx  (key_idx),
    .result   (m)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign last      = ((CW'(chk_idx) + CW'(1)) == used_entries);
  assign in_range  = ({1'b0, unit_q} < 9'(used_entries));

  always_comb begin
    state_next      = state;
    used_next       = used_entries;
    chk_next        = chk_idx;
    zero_found_next = zero_found;
    zero_idx_next   = zero_idx;
    rd_en           = 1'b0;
    rd_addr         = chk_idx + IW'(1);
    wr_en           = 1'b0;
    wr_addr         = chk_idx;
    wr_data         = rd_data;
    emit            = 1'b0;
    res_unit        = RESULT_NONE;
    res_links       = '0;
    res_prog        = '0;
    res_idx         = '0;
    res_valid       = 1'b0;
    res_full        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          rd_en           = 1'b1;
          chk_next        = '0;
          zero_found_next = 1'b0;
          if (action == ACT_RELEASE || action == ACT_QUERY) begin
            rd_addr    = unit_number[IW-1:0];
            state_next = S_UNIT;
          end else begin
            rd_addr    = '0;
            state_next = (used_entries == '0) ? S_DECIDE : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (m.hit) begin
          // A matching key wins even when its count has dropped to zero.
          if (can_emit) begin
            emit       = 1'b1;
            res_unit   = 9'(chk_idx);
            state_next = S_IDLE;
            if (act == ACT_ACQUIRE) begin
              res_links     = m.links_inc;
              wr_en         = 1'b1;
              wr_data.links = m.links_inc;
            end else begin
              res_links = rd_data.links;
            end
          end
        end else begin
          if (m.zero && !zero_found) begin
            zero_found_next = 1'b1;
            zero_idx_next   = chk_idx;
          end
          if (last) begin
            state_next = S_DECIDE;
          end else begin
            rd_en    = 1'b1;
            chk_next = chk_idx + IW'(1);
          end
        end
      end

      S_DECIDE: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (act == ACT_ACQUIRE) begin
            wr_data.prog_handle = key_prog;
            wr_data.bind_index  = key_idx;
            wr_data.links       = LINK_W'(1);
            if (zero_found) begin
              wr_en     = 1'b1;
              wr_addr   = zero_idx;
              res_unit  = 9'(zero_idx);
              res_links = LINK_W'(1);
            end else if (used_entries < CW'(UNITS)) begin
              wr_en     = 1'b1;
              wr_addr   = used_entries[IW-1:0];
              used_next = used_entries + CW'(1);
              res_unit  = 9'(used_entries);
              res_links = LINK_W'(1);
            end else begin
              res_full = 1'b1;
            end
          end
        end
      end

      S_UNIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (in_range) begin
            res_unit = 9'(unit_q);
            if (act == ACT_RELEASE) begin
              res_links     = m.links_dec;
              wr_en         = !m.zero;
              wr_addr       = unit_q[IW-1:0];
              wr_data.links = m.links_dec;
            end else if (!m.zero) begin
              res_links = rd_data.links;
              res_prog  = rd_data.prog_handle;
              res_idx   = rd_data.bind_index;
              res_valid = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_entries <= '0;
      out_valid    <= 1'b0;
      zero_found   <= 1'b0;
    end else begin
      state        <= state_next;
      used_entries <= used_next;
      zero_found   <= zero_found_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    chk_idx  <= chk_next;
    zero_idx <= zero_idx_next;
    if (in_accept) begin
      act      <= action;
      key_prog <= program_handle;
      key_idx  <= binding_index;
      unit_q   <= unit_number;
    end
    if (emit) begin
      unit_result    <= res_unit;
      link_count_out <= res_links;
      program_out    <= res_prog;
      index_out      <= res_idx;
      query_valid    <= res_valid;
      table_full     <= res_full;
    end
  end

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_entries <= CW'(UNITS))
    else $error("used_entries exceeds the table size");

  // The fill count only ever grows by one entry per transfer.
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used_entries != $past(used_entries)) |->
      (used_entries == $past(used_entries) + CW'(1)))
    else $error("used_entries changed by other than one");

  // A full table reports no unit; a valid query always names a unit.
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!table_full || unit_result == RESULT_NONE) &&
                  (!query_valid || unit_result != RESULT_NONE))
    else $error("result flags disagree with unit_result");

  // The store is written only while an item is being worked on.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE))
    else $error("entry store written while idle");

endmodule

>>> tb/tb_refcounted_binding_unit_table.sv
// ----------------------------------------------------------------------------
// tb_refcounted_binding_unit_table
// Self-checking bench for the binding unit table. A table of directed
// requests covers reset behavior, key extremes, zero-count revival, reuse,
// out-of-range units and a full table. Random traffic follows under several
// idle and stall patterns. Every result is compared field by field against
// the in-bench model of the table or against a result written out by hand.
// ----------------------------------------------------------------------------
module tb_refcounted_binding_unit_table;
  import rbut_pkg::*;

  localparam int TABLE_UNITS = 16;
  localparam int KEY_POOL = 24;
  localparam int HOLD_CYCLES = 300;
  // About 1300 requests, each a full table scan at worst plus idling and one long
  // hold-off, taken several times over.
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic signed [8:0]  unit_res;
    logic [15:0]        links;
    logic [31:0]        prog;
    logic signed [31:0] idx;
    logic               qvalid;
    logic               full;
  } binding_result_t;

  typedef struct packed {
    logic [1:0]         act;
    logic [31:0]        prog;
    logic signed [31:0] idx;
    logic [7:0]         unit;
    logic               typed;
    binding_result_t    want;
  } request_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_ACQUIRE;
  logic [31:0]        program_handle = '0;
  logic signed [31:0] binding_index = '0;
  logic [7:0]         unit_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [8:0]  unit_result;
  logic [15:0]        link_count_out;
  logic [31:0]        program_out;
  logic signed [31:0] index_out;
  logic               query_valid;
  logic               table_full;

  // Model of the unit store.
  int                 tbl_used;
  logic [31:0]        tbl_prog [TABLE_UNITS];
  logic signed [31:0] tbl_idx [TABLE_UNITS];
  logic [15:0]        tbl_links [TABLE_UNITS];

  logic [31:0]        pool_prog [KEY_POOL];
  logic signed [31:0] pool_idx [KEY_POOL];

  binding_result_t expected_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int full_seen = 0;
  int cycle_count = 0;
  logic [15:0] peak_links = '0;

  refcounted_binding_unit_table #(.UNITS(TABLE_UNITS)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .program_handle (program_handle),
    .binding_index  (binding_index),
    .unit_number    (unit_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .unit_result    (unit_result),
    .link_count_out (link_count_out),
    .program_out    (program_out),
    .index_out      (index_out),
    .query_valid    (query_valid),
    .table_full     (table_full)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb_refcounted_binding_unit_table failed");
      $finish;
    end
  end

  function automatic int find_binding(logic [31:0] prog, logic signed [31:0] idx);
    for (int k = 0; k < tbl_used; k++) begin
      if (tbl_prog[k] == prog && tbl_idx[k] == idx) return k;
    end
    return -1;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic binding_result_t predict_binding(request_t req);
    binding_result_t r;
    int slot;
    r = '0;
    r.unit_res = RESULT_NONE;
    case (req.act)
      ACT_ACQUIRE: begin
        slot = find_binding(req.prog, req.idx);
        if (slot >= 0) begin
          if (tbl_links[slot] != LINK_MAX) tbl_links[slot]++;
          r.unit_res = 9'(slot);
          r.links = tbl_links[slot];
        end else begin
          for (int k = 0; k < tbl_used; k++) begin
            if (slot < 0 && tbl_links[k] == 0) slot = k;
          end
          if (slot < 0 && tbl_used < TABLE_UNITS) begin
            slot = tbl_used;
            tbl_used++;
          end
          if (slot < 0) begin
            r.full = 1'b1;
          end else begin
            tbl_prog[slot] = req.prog;
            tbl_idx[slot] = req.idx;
            tbl_links[slot] = 16'd1;
            r.unit_res = 9'(slot);
            r.links = 16'd1;
          end
        end
      end
      ACT_GET: begin
        slot = find_binding(req.prog, req.idx);
        if (slot >= 0) begin
          r.unit_res = 9'(slot);
          r.links = tbl_links[slot];
        end
      end
      ACT_RELEASE: begin
        if (int'(req.unit) < tbl_used) begin
          if (tbl_links[req.unit] != 0) tbl_links[req.unit]--;
          r.unit_res = 9'(req.unit);
          r.links = tbl_links[req.unit];
        end
      end
      default: begin
        if (int'(req.unit) < tbl_used) begin
          r.unit_res = 9'(req.unit);
          if (tbl_links[req.unit] != 0) begin
            r.links = tbl_links[req.unit];
            r.prog = tbl_prog[req.unit];
            r.idx = tbl_idx[req.unit];
            r.qvalid = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic request_t cmd(logic [1:0] act, logic [31:0] prog,
                                   logic signed [31:0] idx, logic [7:0] unit);
    request_t r;
    r = '0;
    r.act = act;
    r.prog = prog;
    r.idx = idx;
    r.unit = unit;
    return r;
  endfunction

  // Row whose result is written out by hand; key and query fields are zero.
  function automatic request_t cmd_want(logic [1:0] act, logic [31:0] prog,
                                        logic signed [31:0] idx, logic [7:0] unit,
                                        logic signed [8:0] ures, logic [15:0] links,
                                        logic full);
    request_t r;
    r = cmd(act, prog, idx, unit);
    r.typed = 1'b1;
    r.want.unit_res = ures;
    r.want.links = links;
    r.want.full = full;
    return r;
  endfunction

  // Keys come mostly from a small pool or from live entries so that matches,
  // revivals and a full table keep occurring.
  function automatic request_t random_request();
    request_t r;
    int pick;
    int k;
    r = '0;
    r.act = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 45) begin
      k = $urandom_range(KEY_POOL - 1);
      r.prog = pool_prog[k];
      r.idx = pool_idx[k];
    end else if (pick < 70 && tbl_used > 0) begin
      k = $urandom_range(tbl_used - 1);
      r.prog = tbl_prog[k];
      r.idx = tbl_idx[k];
    end else begin
      r.prog = $urandom;
      r.idx = $urandom;
    end
    if ($urandom_range(99) < 75) r.unit = 8'($urandom_range(tbl_used));
    else r.unit = 8'($urandom_range(255));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input request_t req);
    binding_result_t model_out;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = req.act;
    program_handle = req.prog;
    binding_index = req.idx;
    unit_number = req.unit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_out = predict_binding(req);
    expected_results = {expected_results, (req.typed ? req.want : model_out)};
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // The receiver counts a long hold-off itself once one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    fail_count++;
  endfunction

  always @(posedge clk) begin : result_monitor
    binding_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual unit %0d",
                 $time, unit_result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (unit_result !== want.unit_res)
          note_mismatch("unit_result", 64'(want.unit_res), 64'(unit_result));
        if (link_count_out !== want.links)
          note_mismatch("link_count_out", 64'(want.links), 64'(link_count_out));
        if (program_out !== want.prog)
          note_mismatch("program_out", 64'(want.prog), 64'(program_out));
        if (index_out !== want.idx)
          note_mismatch("index_out", 64'(want.idx), 64'(index_out));
        if (query_valid !== want.qvalid)
          note_mismatch("query_valid", 64'(want.qvalid), 64'(query_valid));
        if (table_full !== want.full)
          note_mismatch("table_full", 64'(want.full), 64'(table_full));
        checked_count++;
        if (table_full === 1'b1) full_seen++;
        if (link_count_out > peak_links) peak_links = link_count_out;
      end
    end
  end

  initial begin : stimulus
    request_t script[$];
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 51, 0, 20};
    stall_tab = '{0, 0, 51, 20};
    tbl_used = 0;
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_prog[k] = $urandom;
      pool_idx[k] = $urandom;
    end
    pool_prog[0] = 32'h0000_0000;
    pool_idx[0] = 32'sh8000_0000;
    pool_prog[1] = 32'hFFFF_FFFF;
    pool_idx[1] = 32'sh7FFF_FFFF;
    pool_prog[2] = 32'hFFFF_FFFF;
    pool_idx[2] = -32'sd1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table first, then key extremes.
    script = {script, cmd_want(ACT_QUERY, 0, 0, 8'd0, RESULT_NONE, 16'd0, 1'b0)};
    script = {script, cmd_want(ACT_RELEASE, 0, 0, 8'd0, RESULT_NONE, 16'd0, 1'b0)};
    script = {script, cmd_want(ACT_GET, 0, 0, 8'd0, RESULT_NONE, 16'd0, 1'b0)};
    script = {script, cmd_want(ACT_ACQUIRE, 0, 0, 8'd0, 9'sd0, 16'd1, 1'b0)};
    script = {script, cmd_want(ACT_ACQUIRE, 32'hFFFF_FFFF, 32'sh8000_0000, 8'd0,
                               9'sd1, 16'd1, 1'b0)};
    script = {script, cmd_want(ACT_ACQUIRE, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'd255,
                               9'sd2, 16'd1, 1'b0)};
    script = {script, cmd(ACT_ACQUIRE, 0, 0, 8'd0)};
    script = {script, cmd(ACT_GET, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'd0)};
    script = {script, cmd(ACT_QUERY, 0, 0, 8'd1)};
    script = {script, cmd_want(ACT_QUERY, 0, 0, 8'd255, RESULT_NONE, 16'd0, 1'b0)};
    script = {script, cmd_want(ACT_RELEASE, 0, 0, 8'd255, RESULT_NONE, 16'd0, 1'b0)};
    script = {script, cmd_want(ACT_QUERY, 0, 0, 8'd3, RESULT_NONE, 16'd0, 1'b0)};
    // A count dropped to zero stays at zero, and its key can still be found.
    script = {script, cmd(ACT_RELEASE, 0, 0, 8'd2)};
    script = {script, cmd(ACT_RELEASE, 0, 0, 8'd2)};
    script = {script, cmd(ACT_QUERY, 0, 0, 8'd2)};
    script = {script, cmd(ACT_GET, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'd0)};
    script = {script, cmd(ACT_ACQUIRE, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'd0)};
    // A new key takes over the first zero-count unit.
    script = {script, cmd(ACT_RELEASE, 0, 0, 8'd1)};
    script = {script, cmd(ACT_ACQUIRE, 32'h1234_5678, -32'sd5, 8'd0)};
    script = {script, cmd(ACT_GET, 32'hFFFF_FFFF, 32'sh8000_0000, 8'd0)};
    // Fill the remaining units; the last of these already finds no room.
    for (int k = 0; k < 14; k++)
      script = {script, cmd(ACT_ACQUIRE, 32'hA5A5_0000 + k, -32'(k), 8'd0)};
    script = {script, cmd_want(ACT_ACQUIRE, 32'hDEAD_BEEF, -32'sd1, 8'd0,
                               RESULT_NONE, 16'd0, 1'b1)};
    script = {script, cmd(ACT_ACQUIRE, 32'h1234_5678, -32'sd5, 8'd0)};
    foreach (script[k]) send_request(script[k]);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct = stall_tab[p];
      repeat (300) send_request(random_request());
      drain_results();
    end

    // Long receiver hold-off while the sender keeps offering transfers.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (100) send_request(random_request());
    drain_results();

    repeat (40) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results, %0d of them table-full,",
             sent_count, checked_count, full_seen);
    $display("with a peak link count of %0d over five idle and stall patterns.", peak_links);
    if (fail_count == 0) begin
      $display("tb_refcounted_binding_unit_table passed");
    end else begin
      $display("tb_refcounted_binding_unit_table failed");
    end
    $finish;
  end

endmodule
